>>> hw/rtl/itcdv_pkg.sv
// Package with the shared types, codes and character constants of the ISBN check-digit verifier.
package itcdv_pkg;

	// Parse phase of the current line.
	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_PREFIX = 3'd1,
		PH_GAP    = 3'd2,
		PH_DIGITS = 3'd3,
		PH_TAIL   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	// Number form found by the parser.
	typedef enum logic [1:0] {
		FMT_PENDING  = 2'd0,
		FMT_TEN      = 2'd1,
		FMT_THIRTEEN = 2'd2,
		FMT_BAD      = 2'd3
	} fmt_t;

	// Verdict codes on the status field.
	localparam logic [1:0] STATUS_PASS      = 2'd0;
	localparam logic [1:0] STATUS_FAIL      = 2'd1;
	localparam logic [1:0] STATUS_MALFORMED = 2'd2;

	// Digit value that stands for an X check digit.
	localparam logic [3:0] DIGIT_X = 4'd10;

	// Digit counts that matter to the parser.
	localparam logic [3:0] COUNT_ISBN10 = 4'd10;
	localparam logic [3:0] COUNT_ISBN13 = 4'd13;
	localparam logic [3:0] COUNT_X_POS  = 4'd9;
	localparam logic [3:0] COUNT_SUM11  = 4'd9;
	localparam logic [3:0] COUNT_SUM10  = 4'd12;

	// Prefix length and character codes.
	localparam logic [2:0] PREFIX_LEN = 3'd4;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UI    = 8'h49;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LX    = 8'h78;

	// Expected prefix character at each matched position.
	function automatic logic [7:0] prefix_char(input logic [1:0] pos);
		logic [7:0] ch;
		unique case (pos)
			2'd0: ch = 8'h49;
			2'd1: ch = 8'h53;
			2'd2: ch = 8'h42;
			2'd3: ch = 8'h4E;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Parser state of one line.
	typedef struct packed {
		phase_t     phase;
		logic [2:0] prefix_matched;
		logic [3:0] digit_count;
		logic       after_sep;
		logic [3:0] psum;
		logic [3:0] wsum;
		logic [3:0] asum;
		logic [3:0] last_digit;
		fmt_t       fmt;
	} parse_t;

	localparam parse_t PARSE_RESET = '{
		phase: PH_LEAD, prefix_matched: 3'd0, digit_count: 4'd0, after_sep: 1'b0,
		psum: 4'd0, wsum: 4'd0, asum: 4'd0, last_digit: 4'd0, fmt: FMT_PENDING
	};

endpackage

>>> hw/rtl/itcdv_if.sv
// Stream interfaces for the character input and the verdict output.
interface itcdv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_end;

	modport source(output valid, char_code, is_end, input ready);
	modport sink(input valid, char_code, is_end, output ready);
endinterface

interface itcdv_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic       is_isbn13;
	logic [3:0] correct_digit;

	modport source(output valid, status, is_isbn13, correct_digit, input ready);
	modport sink(input valid, status, is_isbn13, correct_digit, output ready);
endinterface

>>> hw/rtl/isbn_text_check_digit_verifier_unit.sv
// Top level of the ISBN-10/ISBN-13 text check-digit verifier.
// The block takes one text byte per beat on byte_ch and gives one verdict beat on
// verdict_ch for each beat marked is_end: pass, fail with the correct check digit, or
// malformed. A byte beat is registered, then the parse logic updates the
// running mod-11 and mod-10 sums and the parse phase, and an end beat loads the verdict
// into the output register. The block takes a new beat every cycle; it stalls only
// when an end beat meets a verdict that has not yet been taken. An accepted end beat
// waits in the input register, and its verdict is then loaded into the output register,
// where it stays offered until it is taken.
module isbn_text_check_digit_verifier_unit
	import itcdv_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	itcdv_in_if.sink       byte_ch,
	itcdv_out_if.source    verdict_ch
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	// Parser state and output register.
	parse_t     st_q;
	parse_t     nxt;
	parse_t     dig;
	logic       out_valid_q;
	logic [1:0] status_q;
	logic       isbn13_q;
	logic [3:0] digit_q;

	logic       out_free;
	logic       adv_s1;
	logic       fire_s1;

	// Handshake: an end beat needs a free output register to leave stage 1.
	assign out_free = !out_valid_q || verdict_ch.ready;
	assign adv_s1   = !end_s1 || out_free;
	assign fire_s1  = valid_s1 && adv_s1;
	assign byte_ch.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			char_s1 <= byte_ch.char_code;
			end_s1  <= byte_ch.is_end;
		end
	end

	// Byte classification; the end beat acts as a zero byte.
	logic [7:0] b;
	logic       is_digit;
	logic       is_alnum;
	logic       is_blank;
	logic       is_sep;
	logic       is_x;
	logic [3:0] d;

	assign b        = end_s1 ? CH_NUL : char_s1;
	assign is_digit = (b >= CH_0) && (b <= CH_9);
	assign is_alnum = is_digit || ((b >= CH_UA) && (b <= CH_UZ)) ||
		((b >= CH_LA) && (b <= CH_LZ));
	assign is_blank = (b == CH_SPACE) || (b == CH_TAB);
	assign is_sep   = (b == CH_SPACE) || (b == CH_DASH);
	assign is_x     = (b == CH_UX) || (b == CH_LX);
	assign d        = 4'(b - CH_0);

	// Running sums for a digit byte.
	logic [4:0] p_add;
	logic [3:0] p_new;
	logic [4:0] w_add;
	logic [3:0] w_new;
	logic [4:0] a_term;
	logic [5:0] a_add;
	logic [3:0] a_new;

	always_comb begin
		p_add = {1'b0, st_q.psum} + {1'b0, d};
		p_new = (p_add >= 5'd11) ? 4'(p_add - 5'd11) : p_add[3:0];
		w_add = {1'b0, st_q.wsum} + {1'b0, p_new};
		w_new = (w_add >= 5'd11) ? 4'(w_add - 5'd11) : w_add[3:0];
		a_term = st_q.digit_count[0] ? ({1'b0, d} + {d, 1'b0}) : {1'b0, d};
		a_add  = {2'b00, st_q.asum} + {1'b0, a_term};
		priority if (a_add >= 6'd30) begin
			a_new = 4'(a_add - 6'd30);
		end else if (a_add >= 6'd20) begin
			a_new = 4'(a_add - 6'd20);
		end else if (a_add >= 6'd10) begin
			a_new = 4'(a_add - 6'd10);
		end else begin
			a_new = a_add[3:0];
		end
	end

	// Next state when the byte is handled as part of the digit run.
	always_comb begin
		dig = st_q;
		dig.phase = PH_DIGITS;
		priority if (st_q.digit_count >= COUNT_ISBN13) begin
			dig.phase = PH_DONE;
			dig.fmt   = is_alnum ? FMT_BAD : FMT_THIRTEEN;
		end else if (!st_q.after_sep && is_sep) begin
			dig.after_sep = 1'b1;
		end else if (is_digit) begin
			if (st_q.digit_count < COUNT_SUM11) begin
				dig.psum = p_new;
				dig.wsum = w_new;
			end
			if (st_q.digit_count < COUNT_SUM10) begin
				dig.asum = a_new;
			end
			dig.last_digit  = d;
			dig.digit_count = st_q.digit_count + 4'd1;
			dig.after_sep   = 1'b0;
		end else if (st_q.digit_count == COUNT_X_POS && is_x) begin
			dig.last_digit  = DIGIT_X;
			dig.digit_count = COUNT_ISBN10;
			dig.after_sep   = 1'b0;
			dig.phase       = PH_TAIL;
		end else begin
			dig.phase = PH_DONE;
			dig.fmt   = (st_q.digit_count == COUNT_ISBN10 && !is_alnum) ? FMT_TEN : FMT_BAD;
		end
	end

	// Phase logic of the line parser.
	always_comb begin
		nxt = st_q;
		unique case (st_q.phase)
			PH_LEAD: begin
				if (is_blank) begin
					nxt = st_q;
				end else if (b == CH_UI) begin
					nxt.prefix_matched = 3'd1;
					nxt.phase          = PH_PREFIX;
				end else begin
					nxt = dig;
				end
			end
			PH_PREFIX: begin
				if (st_q.prefix_matched < PREFIX_LEN &&
					b == prefix_char(st_q.prefix_matched[1:0])) begin
					nxt.prefix_matched = st_q.prefix_matched + 3'd1;
					if (st_q.prefix_matched + 3'd1 == PREFIX_LEN) begin
						nxt.phase = PH_GAP;
					end
				end else begin
					nxt.phase = PH_DONE;
					nxt.fmt   = FMT_BAD;
				end
			end
			PH_GAP: begin
				if (!is_blank) begin
					nxt = dig;
				end
			end
			PH_DIGITS: begin
				nxt = dig;
			end
			PH_TAIL: begin
				nxt.phase = PH_DONE;
				nxt.fmt   = is_alnum ? FMT_BAD : FMT_TEN;
			end
			default: begin
				nxt = st_q;
			end
		endcase
	end

	// Check digits and verdict from the state after the end beat.
	logic [4:0] s11_add;
	logic [3:0] s11;
	logic [3:0] c10;
	logic [3:0] c13;
	logic [1:0] v_status;
	logic       v_isbn13;
	logic [3:0] v_digit;

	always_comb begin
		s11_add = {1'b0, nxt.wsum} + {1'b0, nxt.psum};
		s11 = (s11_add >= 5'd11) ? 4'(s11_add - 5'd11) : s11_add[3:0];
		c10 = (s11 == 4'd0) ? 4'd0 : 4'(5'd11 - {1'b0, s11});
		c13 = (nxt.asum == 4'd0) ? 4'd0 : 4'(5'd10 - {1'b0, nxt.asum});
		unique case (nxt.fmt)
			FMT_TEN: begin
				v_status = (c10 == nxt.last_digit) ? STATUS_PASS : STATUS_FAIL;
				v_isbn13 = 1'b0;
				v_digit  = c10;
			end
			FMT_THIRTEEN: begin
				v_status = (c13 == nxt.last_digit) ? STATUS_PASS : STATUS_FAIL;
				v_isbn13 = 1'b1;
				v_digit  = c13;
			end
			default: begin
				v_status = STATUS_MALFORMED;
				v_isbn13 = 1'b0;
				v_digit  = 4'd0;
			end
		endcase
	end

	// Parser state update; an end beat returns it to the line start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_RESET;
		end else if (fire_s1) begin
			st_q <= end_s1 ? PARSE_RESET : nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && end_s1) begin
			status_q <= v_status;
			isbn13_q <= v_isbn13;
			digit_q  <= v_digit;
		end
	end

	assign verdict_ch.valid         = out_valid_q;
	assign verdict_ch.status        = status_q;
	assign verdict_ch.is_isbn13     = isbn13_q;
	assign verdict_ch.correct_digit = digit_q;

endmodule

>>> hw/rtl/itcdv_checker.sv
// Port checker for the ISBN check-digit verifier, bound to the top level.
module itcdv_checker
	import itcdv_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic       is_isbn13,
	input logic [3:0] correct_digit
);

	// A verdict beat stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("verdict beat dropped while stalled");

	// Only the three verdict codes appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_PASS || status == STATUS_FAIL ||
			status == STATUS_MALFORMED))
		else $error("invalid status code");

	// A malformed verdict carries no form and no digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_MALFORMED |-> !is_isbn13 && correct_digit == 4'd0)
		else $error("malformed verdict with form or digit");

	// Check digit range depends on the form: X only for ten digits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_isbn13 ? correct_digit <= 4'd9 : correct_digit <= DIGIT_X))
		else $error("check digit out of range for its form");

endmodule

bind isbn_text_check_digit_verifier_unit itcdv_checker u_itcdv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (verdict_ch.valid),
	.out_ready     (verdict_ch.ready),
	.status        (verdict_ch.status),
	.is_isbn13     (verdict_ch.is_isbn13),
	.correct_digit (verdict_ch.correct_digit)
);

>>> tb/isbn_text_check_digit_verifier_unit_tb.sv
// Self-checking testbench for the ISBN text check-digit verifier: directed lines, then random lines.
module isbn_text_check_digit_verifier_unit_tb;
	import itcdv_pkg::*;

	// One verdict beat as seen on the output channel.
	typedef struct packed {
		logic [1:0] status;
		logic       is13;
		logic [3:0] digit;
	} verdict_t;

	// Parser state of the line being fed, kept by the testbench.
	typedef struct packed {
		phase_t     ph;
		logic [2:0] pfx;
		logic [3:0] cnt;
		logic       sep;
		logic [3:0] sum9;
		logic [3:0] wsum9;
		logic [3:0] alt12;
		logic [3:0] last_dig;
		fmt_t       form;
	} line_parse_t;

	// A line of the directed table, with a typed verdict where it is obvious.
	typedef struct {
		string      text;
		bit         add_byte;
		logic [7:0] extra;
		bit         typed;
		verdict_t   want;
	} directed_row_t;

	localparam line_parse_t FRESH_LINE = '{ph: PH_LEAD, pfx: 3'd0, cnt: 4'd0, sep: 1'b0,
		sum9: 4'd0, wsum9: 4'd0, alt12: 4'd0, last_dig: 4'd0, form: FMT_PENDING};
	localparam verdict_t MALFORMED_VERDICT = '{status: STATUS_MALFORMED, is13: 1'b0,
		digit: 4'd0};
	localparam logic [31:0] PREFIX_WORD = "ISBN";
	localparam string NOISE_CHARS = "0123456789 -Xx\tISBNa.";
	localparam int RANDOM_BEATS = 1450;
	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	directed_row_t directed_rows [20] = '{
		'{"", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT},
		'{"0306406152", 1'b0, 8'h00, 1'b0, MALFORMED_VERDICT},
		'{"ISBN 0-306-40615-2", 1'b0, 8'h00, 1'b0, MALFORMED_VERDICT},
		'{" \tISBN\t 978-0-306-40615-7", 1'b0, 8'h00, 1'b0, MALFORMED_VERDICT},
		'{"0-8044-2957-X", 1'b0, 8'h00, 1'b0, MALFORMED_VERDICT},
		'{"080442957x", 1'b0, 8'h00, 1'b0, MALFORMED_VERDICT},
		'{"9780306406158", 1'b0, 8'h00, 1'b0, MALFORMED_VERDICT},
		'{"ISB9780306406157", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT},
		'{"I", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT},
		'{"ISBN", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT},
		'{"0306406152", 1'b1, 8'h00, 1'b0, MALFORMED_VERDICT},
		'{"9780306406157", 1'b1, 8'hFF, 1'b0, MALFORMED_VERDICT},
		'{"03064061521", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT},
		'{"97803064061570", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT},
		'{"0306406152a", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT},
		'{"030--6406152", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT},
		'{"978030640615X", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT},
		'{"0306406152, tail ISBN 12", 1'b0, 8'h00, 1'b0, MALFORMED_VERDICT},
		'{"", 1'b1, 8'hFF, 1'b1, MALFORMED_VERDICT},
		'{"X", 1'b0, 8'h00, 1'b1, MALFORMED_VERDICT}
	};

	logic clk;
	logic arst_n;

	itcdv_in_if  byte_ch();
	itcdv_out_if verdict_ch();

	isbn_text_check_digit_verifier_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.verdict_ch(verdict_ch)
	);

	line_parse_t line_state = FRESH_LINE;
	verdict_t    pending_verdicts [$];
	logic [7:0]  line_buf [$];
	bit          typed_pending = 1'b0;
	verdict_t    typed_want;
	bit          steady = 1'b0;
	int          beats_sent = 0;
	int          mismatches = 0;
	int          idle_cycles = 0;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_alnum(logic [7:0] b);
		return (b >= CH_0 && b <= CH_9) || (b >= CH_UA && b <= CH_UZ) ||
			(b >= CH_LA && b <= CH_LZ);
	endfunction

	function automatic bit is_blank(logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB;
	endfunction

	// One byte in the digit part: separators, digits, an X in tenth place, or the end of it.
	function automatic line_parse_t number_byte(line_parse_t p, logic [7:0] b);
		int d;
		p.ph = PH_DIGITS;
		if (p.cnt >= COUNT_ISBN13) begin
			p.form = is_alnum(b) ? FMT_BAD : FMT_THIRTEEN;
			p.ph = PH_DONE;
		end else if (!p.sep && (b == CH_SPACE || b == CH_DASH)) begin
			p.sep = 1'b1;
		end else if (b >= CH_0 && b <= CH_9) begin
			d = int'(b - CH_0);
			if (p.cnt < COUNT_SUM11) begin
				p.sum9 = 4'((int'(p.sum9) + d) % 11);
				p.wsum9 = 4'((int'(p.wsum9) + int'(p.sum9)) % 11);
			end
			if (p.cnt < COUNT_SUM10)
				p.alt12 = 4'((int'(p.alt12) + (p.cnt[0] ? 3 * d : d)) % 10);
			p.last_dig = 4'(d);
			p.cnt = p.cnt + 4'd1;
			p.sep = 1'b0;
		end else if (p.cnt == COUNT_X_POS && (b == CH_UX || b == CH_LX)) begin
			p.last_dig = DIGIT_X;
			p.cnt = COUNT_ISBN10;
			p.sep = 1'b0;
			p.ph = PH_TAIL;
		end else begin
			p.form = (p.cnt == COUNT_ISBN10 && !is_alnum(b)) ? FMT_TEN : FMT_BAD;
			p.ph = PH_DONE;
		end
		return p;
	endfunction

	// Advances the line parser by one text byte.
	function automatic line_parse_t parse_byte(line_parse_t p, logic [7:0] b);
		case (p.ph)
			PH_LEAD: begin
				if (b == CH_UI) begin
					p.pfx = 3'd1;
					p.ph = PH_PREFIX;
				end else if (!is_blank(b)) begin
					p = number_byte(p, b);
				end
			end
			PH_PREFIX: begin
				if (p.pfx < PREFIX_LEN && b == PREFIX_WORD[31 - 8 * int'(p.pfx) -: 8]) begin
					p.pfx = p.pfx + 3'd1;
					if (p.pfx == PREFIX_LEN)
						p.ph = PH_GAP;
				end else begin
					p.form = FMT_BAD;
					p.ph = PH_DONE;
				end
			end
			PH_GAP: begin
				if (!is_blank(b))
					p = number_byte(p, b);
			end
			PH_DIGITS: p = number_byte(p, b);
			PH_TAIL: begin
				p.form = is_alnum(b) ? FMT_BAD : FMT_TEN;
				p.ph = PH_DONE;
			end
			default: ;
		endcase
		return p;
	endfunction

	// The end beat works as a zero byte; then the check digit of the found form is derived.
	function automatic verdict_t close_line(line_parse_t p);
		verdict_t v;
		int c;
		if (p.ph != PH_DONE)
			p = parse_byte(p, CH_NUL);
		v = MALFORMED_VERDICT;
		case (p.form)
			FMT_TEN: begin
				c = (11 - (int'(p.wsum9) + int'(p.sum9)) % 11) % 11;
				v.status = (c == int'(p.last_dig)) ? STATUS_PASS : STATUS_FAIL;
				v.is13 = 1'b0;
				v.digit = 4'(c);
			end
			FMT_THIRTEEN: begin
				c = (10 - int'(p.alt12) % 10) % 10;
				v.status = (c == int'(p.last_dig)) ? STATUS_PASS : STATUS_FAIL;
				v.is13 = 1'b1;
				v.digit = 4'(c);
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, verdict_t want, verdict_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s: status %0d/%0d is_isbn13 %0d/%0d correct_digit %0d/%0d",
				what, want.status, got.status, want.is13, got.is13, want.digit, got.digit);
	endtask

	// Input beats drive the line parser; an end beat yields the expected verdict.
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			if (byte_ch.is_end) begin
				v = close_line(line_state);
				if (typed_pending) begin
					v = typed_want;
					typed_pending = 1'b0;
				end
				pending_verdicts.push_back(v);
				line_state = FRESH_LINE;
			end else begin
				line_state = parse_byte(line_state, byte_ch.char_code);
			end
		end
	end

	// Verdict beats are checked against the oldest expected verdict.
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			got = '{status: verdict_ch.status, is13: verdict_ch.is_isbn13,
				digit: verdict_ch.correct_digit};
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unexpected verdict (expected/actual)", '0, got);
			end else begin
				want = pending_verdicts.pop_front();
				if (got.status != want.status || got.is13 != want.is13 ||
						got.digit != want.digit)
					report_mismatch("verdict mismatch (expected/actual)", want, got);
			end
		end
	end

	// Random back-pressure on the verdict channel.
	always @(negedge clk) begin
		verdict_ch.ready = steady || ($urandom_range(0, 99) >= 22);
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) ||
				(verdict_ch.valid && verdict_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Drives one beat from a falling edge and returns at the falling edge after acceptance.
	task automatic send_beat(input logic [7:0] ch, input logic fin);
		steady = beats_sent >= 700 && beats_sent < 950;
		while (!steady && $urandom_range(0, 99) < 22) begin
			byte_ch.valid = 1'b0;
			@(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.char_code = ch;
		byte_ch.is_end = fin;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_beat(line_buf[i], 1'b0);
		send_beat(8'($urandom_range(0, 255)), 1'b1);
		line_buf.delete();
	endtask

	task automatic push_noise_byte();
		if ($urandom_range(0, 1))
			line_buf.push_back(8'($urandom_range(0, 255)));
		else
			line_buf.push_back(NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)]);
	endtask

	task automatic push_blanks(int most);
		repeat ($urandom_range(0, most))
			line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
	endtask

	// Appends a digit run; a good ten- or thirteen-digit run gets its correct check digit.
	task automatic push_number(int digits, bit good);
		int spot;
		line_parse_t p;
		verdict_t v;
		spot = -1;
		for (int i = 0; i < digits; i++) begin
			if ($urandom_range(0, 3) == 0)
				line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_DASH);
			spot = line_buf.size();
			line_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
		end
		if (digits == 10 && $urandom_range(0, 9) == 0)
			line_buf[spot] = $urandom_range(0, 1) ? CH_UX : CH_LX;
		if (good && (digits == 10 || digits == 13)) begin
			p = FRESH_LINE;
			foreach (line_buf[i])
				p = parse_byte(p, line_buf[i]);
			v = close_line(p);
			if (v.digit == DIGIT_X)
				line_buf[spot] = $urandom_range(0, 1) ? CH_UX : CH_LX;
			else
				line_buf[spot] = CH_0 + 8'(v.digit);
		end
	endtask

	// Optional blanks and prefix, the number, and sometimes a delimiter with trailing bytes.
	task automatic push_isbn_line(int digits, bit good);
		logic [7:0] b;
		push_blanks($urandom_range(0, 1) ? 3 : 0);
		if ($urandom_range(0, 99) < 40) begin
			for (int k = 0; k < 4; k++)
				line_buf.push_back(PREFIX_WORD[31 - 8 * k -: 8]);
			push_blanks(2);
		end
		push_number(digits, good);
		if ($urandom_range(0, 1)) begin
			do
				b = 8'($urandom_range(0, 255));
			while (is_alnum(b));
			line_buf.push_back(b);
			repeat ($urandom_range(0, 4))
				push_noise_byte();
		end
	endtask

	// Damages a line by one replaced, inserted or dropped byte, or cuts the prefix short.
	task automatic break_line();
		int spot;
		spot = (line_buf.size() == 0) ? 0 : $urandom_range(0, line_buf.size() - 1);
		case ($urandom_range(0, 3))
			0: begin
				if (line_buf.size() != 0)
					line_buf.delete(spot);
			end
			1: begin
				push_noise_byte();
				line_buf.insert(spot, line_buf.pop_back());
			end
			2: begin
				if (line_buf.size() != 0) begin
					push_noise_byte();
					line_buf[spot] = line_buf.pop_back();
				end
			end
			default: begin
				line_buf.delete();
				for (int k = 0; k < $urandom_range(1, 3); k++)
					line_buf.push_back(PREFIX_WORD[31 - 8 * k -: 8]);
				push_noise_byte();
				push_number($urandom_range(0, 13), 1'b0);
			end
		endcase
	endtask

	// Reset, directed lines, random lines, then drain and verdict.
	initial begin
		int pick;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.char_code = 8'h00;
		byte_ch.is_end = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[r]) begin
			for (int i = 0; i < directed_rows[r].text.len(); i++)
				line_buf.push_back(directed_rows[r].text[i]);
			if (directed_rows[r].add_byte)
				line_buf.push_back(directed_rows[r].extra);
			typed_pending = directed_rows[r].typed;
			typed_want = directed_rows[r].want;
			send_line();
		end

		while (beats_sent < RANDOM_BEATS) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				push_isbn_line($urandom_range(0, 1) ? 10 : 13, $urandom_range(0, 99) < 60);
			end else if (pick < 85) begin
				push_isbn_line($urandom_range(0, 1) ? $urandom_range(0, 15) :
					($urandom_range(0, 1) ? 10 : 13), 1'b1);
				break_line();
			end else begin
				repeat ($urandom_range(0, 16))
					push_noise_byte();
			end
			send_line();
		end
		byte_ch.valid = 1'b0;

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
